// File: rtl/khrt_pkg.sv
// shared types and constants for the key hold and repeat trigger
package khrt_pkg;

   localparam int TICK_WIDTH = 32;
   localparam int DELAY_WIDTH = 32;
   localparam int CMP_WIDTH = (TICK_WIDTH > DELAY_WIDTH) ? TICK_WIDTH : DELAY_WIDTH;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_KEY = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TRIGGER_ON_RELEASE = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HOLD_DELAY = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REPEAT_DELAY = 4'd3;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_KEY_EVENT = 1'b1;

   localparam logic [7:0] POS_RELEASED = 8'd0;
   localparam logic [7:0] POS_PRESSED = 8'd255;

   localparam logic [1:0] EV_BEGIN = 2'd0;
   localparam logic [1:0] EV_SUCCESS = 2'd1;
   localparam logic [1:0] EV_CANCEL = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RUN = 2'd1,
      PH_REPEAT = 2'd2
   } phase_type;

   typedef struct packed {
      logic req_type;
      logic [7:0] key_code;
      logic [7:0] position;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] target_key;
      logic trigger_on_release;
      logic [DELAY_WIDTH-1:0] hold_delay;
      logic [DELAY_WIDTH-1:0] repeat_delay;
   } cfg_type;

   typedef struct packed {
      phase_type phase;
      logic [TICK_WIDTH-1:0] ticks_since_start;
      logic [TICK_WIDTH-1:0] ticks_since_success;
   } state_type;

   typedef struct packed {
      logic [1:0] count;
      logic [1:0] kind0;
      logic [1:0] kind1;
   } results_type;

endpackage

// File: rtl/khrt_step.sv
// next state and results for one transaction
module khrt_step (
   input khrt_pkg::cfg_type cfg,
   input khrt_pkg::state_type state_cur,
   input khrt_pkg::req_payload_type req,
   output khrt_pkg::state_type state_nxt,
   output khrt_pkg::results_type results
);

   logic [khrt_pkg::TICK_WIDTH-1:0] start_inc;
   logic [khrt_pkg::TICK_WIDTH-1:0] success_inc;
   logic [khrt_pkg::CMP_WIDTH-1:0] start_inc_x;
   logic [khrt_pkg::CMP_WIDTH-1:0] success_inc_x;
   logic [khrt_pkg::CMP_WIDTH-1:0] start_cur_x;
   logic [khrt_pkg::CMP_WIDTH-1:0] hold_x;
   logic [khrt_pkg::CMP_WIDTH-1:0] repeat_x;
   logic is_tick;
   logic is_key;
   logic match;
   logic reversed;
   logic tick_repeat_fire;
   logic tick_run_fire;
   logic hold_zero;
   logic event_hold_met;

   assign start_inc = (&state_cur.ticks_since_start) ? state_cur.ticks_since_start
                    : state_cur.ticks_since_start + 1'b1;
   assign success_inc = (&state_cur.ticks_since_success) ? state_cur.ticks_since_success
                      : state_cur.ticks_since_success + 1'b1;

   assign start_inc_x = khrt_pkg::CMP_WIDTH'(start_inc);
   assign success_inc_x = khrt_pkg::CMP_WIDTH'(success_inc);
   assign start_cur_x = khrt_pkg::CMP_WIDTH'(state_cur.ticks_since_start);
   assign hold_x = khrt_pkg::CMP_WIDTH'(cfg.hold_delay);
   assign repeat_x = khrt_pkg::CMP_WIDTH'(cfg.repeat_delay);

   assign is_tick = (req.req_type == khrt_pkg::REQ_TICK);
   assign is_key = (req.req_type == khrt_pkg::REQ_KEY_EVENT) && (req.key_code == cfg.target_key);
   assign match = ((req.position == khrt_pkg::POS_PRESSED) && !cfg.trigger_on_release)
               || ((req.position == khrt_pkg::POS_RELEASED) && cfg.trigger_on_release);
   assign reversed = ((req.position == khrt_pkg::POS_PRESSED) && cfg.trigger_on_release)
                  || ((req.position == khrt_pkg::POS_RELEASED) && !cfg.trigger_on_release);
   assign tick_repeat_fire = (success_inc_x >= repeat_x);
   assign tick_run_fire = (start_inc_x >= hold_x);
   assign hold_zero = (cfg.hold_delay == '0);
   assign event_hold_met = (start_cur_x >= hold_x);

   // next phase
   always_comb begin
      state_nxt.phase = state_cur.phase;
      unique case (state_cur.phase)
         khrt_pkg::PH_IDLE: begin
            if (is_key && match) begin
               state_nxt.phase = hold_zero ? khrt_pkg::PH_REPEAT : khrt_pkg::PH_RUN;
            end
         end
         khrt_pkg::PH_RUN: begin
            if (is_tick) begin
               if (tick_run_fire) begin
                  state_nxt.phase = khrt_pkg::PH_REPEAT;
               end
            end else if (is_key) begin
               if (reversed) begin
                  state_nxt.phase = khrt_pkg::PH_IDLE;
               end else if (event_hold_met) begin
                  state_nxt.phase = khrt_pkg::PH_REPEAT;
               end
            end
         end
         khrt_pkg::PH_REPEAT: begin
            if (is_key && reversed) begin
               state_nxt.phase = khrt_pkg::PH_IDLE;
            end
         end
         default: begin
            state_nxt.phase = state_cur.phase;
         end
      endcase
   end

   // counters and results
   always_comb begin
      state_nxt.ticks_since_start = state_cur.ticks_since_start;
      state_nxt.ticks_since_success = state_cur.ticks_since_success;
      results.count = 2'd0;
      results.kind0 = khrt_pkg::EV_SUCCESS;
      results.kind1 = khrt_pkg::EV_SUCCESS;
      if (is_tick) begin
         state_nxt.ticks_since_start = start_inc;
         state_nxt.ticks_since_success = success_inc;
         if ((state_cur.phase == khrt_pkg::PH_REPEAT) && tick_repeat_fire) begin
            results.count = 2'd1;
            state_nxt.ticks_since_success = '0;
         end else if ((state_cur.phase == khrt_pkg::PH_RUN) && tick_run_fire) begin
            results.count = 2'd1;
            state_nxt.ticks_since_success = '0;
         end
      end else if (is_key) begin
         if (state_cur.phase == khrt_pkg::PH_IDLE) begin
            if (match) begin
               state_nxt.ticks_since_start = '0;
               results.kind0 = khrt_pkg::EV_BEGIN;
               results.count = hold_zero ? 2'd2 : 2'd1;
            end
         end else if (reversed) begin
            results.kind0 = khrt_pkg::EV_CANCEL;
            results.count = 2'd1;
         end else if (event_hold_met) begin
            results.count = 2'd1;
         end
      end
   end

endmodule

// File: rtl/khrt_rsp_buf.sv
// two-entry result queue that takes up to two results per cycle while room is high
module khrt_rsp_buf (
   input logic clock,
   input logic reset,
   input khrt_pkg::results_type push,
   output logic room,
   output logic rsp_valid,
   input logic rsp_ready,
   output khrt_pkg::rsp_payload_type rsp_data
);

   khrt_pkg::rsp_payload_type ent_ff [2];
   logic head_ff;
   logic head_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic pop;
   logic wr0_idx;
   logic wr1_idx;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data = ent_ff[head_ff];
   assign pop = rsp_valid && rsp_ready;
   assign room = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
   assign wr0_idx = head_ff ^ count_ff[0];
   assign wr1_idx = ~wr0_idx;
   assign head_in = head_ff ^ pop;
   assign count_in = count_ff - {1'b0, pop} + push.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         ent_ff[wr0_idx].event_kind <= push.kind0;
         ent_ff[wr0_idx].last_of_run <= (push.count == 2'd1);
      end
      if (push.count == 2'd2) begin
         ent_ff[wr1_idx].event_kind <= push.kind1;
         ent_ff[wr1_idx].last_of_run <= 1'b1;
      end
   end

endmodule

// File: rtl/key_hold_repeat_trigger_core.sv
// key hold and repeat trigger top level
// results: registered in the result queue, shown in the cycle after acceptance
// throughput: one transaction per cycle while each gives at most one result and
//   the result side keeps up; a transaction with two results fills the two-entry
//   result queue, which must pop an entry before the next transaction is accepted
// reset: synchronous, clears phase to idle, start counter to zero,
//   success counter to all ones and the configuration registers to zero
module key_hold_repeat_trigger_core (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input khrt_pkg::req_payload_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output khrt_pkg::rsp_payload_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [khrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [khrt_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   khrt_pkg::cfg_type cfg_ff;
   khrt_pkg::cfg_type cfg_in;
   khrt_pkg::state_type state_ff;
   khrt_pkg::state_type state_in;
   khrt_pkg::state_type state_nxt;
   khrt_pkg::results_type results;
   khrt_pkg::results_type push;
   logic room;
   logic req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = room;
   assign req_fire = req_valid && room;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            khrt_pkg::REG_TARGET_KEY: cfg_in.target_key = csr_data[7:0];
            khrt_pkg::REG_TRIGGER_ON_RELEASE: cfg_in.trigger_on_release = csr_data[0];
            khrt_pkg::REG_HOLD_DELAY:
               cfg_in.hold_delay = csr_data[khrt_pkg::DELAY_WIDTH-1:0];
            khrt_pkg::REG_REPEAT_DELAY:
               cfg_in.repeat_delay = csr_data[khrt_pkg::DELAY_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   khrt_step u_step (
      .cfg(cfg_ff),
      .state_cur(state_ff),
      .req(req_data),
      .state_nxt(state_nxt),
      .results(results)
   );

   always_comb begin
      state_in = req_fire ? state_nxt : state_ff;
      push = results;
      if (!req_fire) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         state_ff.phase <= khrt_pkg::PH_IDLE;
         state_ff.ticks_since_start <= '0;
         state_ff.ticks_since_success <= '1;
      end else begin
         cfg_ff <= cfg_in;
         state_ff <= state_in;
      end
   end

   khrt_rsp_buf u_rsp_buf (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room(room),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// File: sim/key_hold_repeat_trigger_core_test.sv
// self-checking testbench for the key hold and repeat trigger core
`timescale 1ns / 1ps

module key_hold_repeat_trigger_core_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 20;
   localparam int BLOCKS_PER_MODE = 5;
   localparam int ITEMS_PER_BLOCK = 50;
   localparam logic [khrt_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 4'd9;

   typedef struct packed {
      logic typed;
      khrt_pkg::results_type res;
   } typed_result_type;

   typedef struct {
      bit is_csr;
      logic [khrt_pkg::CSR_INDEX_WIDTH-1:0] index;
      logic [khrt_pkg::CSR_DATA_WIDTH-1:0] value;
      khrt_pkg::req_payload_type req;
      bit typed;
      khrt_pkg::results_type res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   khrt_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   khrt_pkg::rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [khrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [khrt_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;

   key_hold_repeat_trigger_core u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // trigger shadow state
   khrt_pkg::cfg_type shadow_cfg = '0;
   khrt_pkg::phase_type shadow_phase = khrt_pkg::PH_IDLE;
   logic [khrt_pkg::TICK_WIDTH-1:0] since_start = '0;
   logic [khrt_pkg::TICK_WIDTH-1:0] since_success = '1;

   khrt_pkg::rsp_payload_type pending_events[$];
   typed_result_type typed_q[$];
   dir_row_type dir_rows[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int failures = 0;
   int items_sent = 0;
   int results_checked = 0;
   int settings_written = 0;
   int idle_cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [khrt_pkg::TICK_WIDTH-1:0] sat_inc(
      input logic [khrt_pkg::TICK_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void add_kind(inout khrt_pkg::results_type r, input logic [1:0] kind);
      if (r.count == 0) r.kind0 = kind;
      else r.kind1 = kind;
      r.count = r.count + 1'b1;
   endfunction

   function automatic khrt_pkg::req_payload_type mk_req(logic t, logic [7:0] k,
                                                        logic [7:0] p);
      khrt_pkg::req_payload_type rq;
      rq.req_type = t;
      rq.key_code = k;
      rq.position = p;
      return rq;
   endfunction

   function automatic khrt_pkg::results_type mk_res(logic [1:0] cnt, logic [1:0] k0,
                                                    logic [1:0] k1);
      khrt_pkg::results_type r;
      r.count = cnt;
      r.kind0 = k0;
      r.kind1 = k1;
      return r;
   endfunction

   task automatic step_trigger(input khrt_pkg::req_payload_type rq,
                               output khrt_pkg::results_type r);
      logic rel;
      logic match;
      logic reversed;
      r = '0;
      if (rq.req_type == khrt_pkg::REQ_TICK) begin
         since_start = sat_inc(since_start);
         since_success = sat_inc(since_success);
         if (shadow_phase == khrt_pkg::PH_REPEAT) begin
            if (since_success >= shadow_cfg.repeat_delay) begin
               add_kind(r, khrt_pkg::EV_SUCCESS);
               since_success = '0;
            end
         end else if (shadow_phase == khrt_pkg::PH_RUN) begin
            if (since_start >= shadow_cfg.hold_delay) begin
               shadow_phase = khrt_pkg::PH_REPEAT;
               add_kind(r, khrt_pkg::EV_SUCCESS);
               since_success = '0;
            end
         end
      end else if (rq.key_code == shadow_cfg.target_key) begin
         rel = shadow_cfg.trigger_on_release;
         match = (rq.position == khrt_pkg::POS_PRESSED && !rel)
              || (rq.position == khrt_pkg::POS_RELEASED && rel);
         reversed = (rq.position == khrt_pkg::POS_PRESSED && rel)
                 || (rq.position == khrt_pkg::POS_RELEASED && !rel);
         if (shadow_phase == khrt_pkg::PH_IDLE) begin
            if (match) begin
               since_start = '0;
               shadow_phase = khrt_pkg::PH_RUN;
               add_kind(r, khrt_pkg::EV_BEGIN);
               if (since_start >= shadow_cfg.hold_delay) begin
                  shadow_phase = khrt_pkg::PH_REPEAT;
                  add_kind(r, khrt_pkg::EV_SUCCESS);
               end
            end
         end else if (reversed) begin
            shadow_phase = khrt_pkg::PH_IDLE;
            add_kind(r, khrt_pkg::EV_CANCEL);
         end else if (since_start >= shadow_cfg.hold_delay) begin
            shadow_phase = khrt_pkg::PH_REPEAT;
            add_kind(r, khrt_pkg::EV_SUCCESS);
         end
      end
   endtask

   // checks results first, since they belong to earlier transactions
   always @(posedge clock) begin
      khrt_pkg::rsp_payload_type want;
      khrt_pkg::results_type pr;
      typed_result_type tr;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               $error("unexpected result: event_kind %0d, last_of_run %0d",
                      rsp_data.event_kind, rsp_data.last_of_run);
               failures++;
            end else begin
               want = pending_events.pop_front();
               results_checked++;
               if (rsp_data.event_kind !== want.event_kind) begin
                  $error("event_kind mismatch: expected %0d, actual %0d",
                         want.event_kind, rsp_data.event_kind);
                  failures++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run mismatch: expected %0d, actual %0d",
                         want.last_of_run, rsp_data.last_of_run);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               khrt_pkg::REG_TARGET_KEY: shadow_cfg.target_key = csr_data[7:0];
               khrt_pkg::REG_TRIGGER_ON_RELEASE: shadow_cfg.trigger_on_release = csr_data[0];
               khrt_pkg::REG_HOLD_DELAY:
                  shadow_cfg.hold_delay = csr_data[khrt_pkg::DELAY_WIDTH-1:0];
               khrt_pkg::REG_REPEAT_DELAY:
                  shadow_cfg.repeat_delay = csr_data[khrt_pkg::DELAY_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            step_trigger(req_data, pr);
            tr = typed_q.pop_front();
            if (tr.typed) pr = tr.res;
            for (int i = 0; i < pr.count; i++) begin
               want.event_kind = (i == 0) ? pr.kind0 : pr.kind1;
               want.last_of_run = (i == pr.count - 1);
               pending_events.push_back(want);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input khrt_pkg::req_payload_type rq, input bit typed,
                            input khrt_pkg::results_type res);
      typed_result_type tr;
      tr.typed = typed;
      tr.res = res;
      typed_q.push_back(tr);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
         req_valid <= 1'b0;
      end while (pending_events.size() != 0);
      repeat (SETTLE_CYCLES) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic write_csr(input logic [khrt_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [khrt_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [khrt_pkg::DELAY_WIDTH-1:0] pick_delay();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) return khrt_pkg::DELAY_WIDTH'($urandom_range(4));
      if (sel < 7) return khrt_pkg::DELAY_WIDTH'($urandom_range(20, 5));
      if (sel == 7) return '0;
      if (sel == 8) return '1;
      return khrt_pkg::DELAY_WIDTH'($urandom);
   endfunction

   task automatic write_random_config();
      logic [7:0] key;
      int sel;
      sel = $urandom_range(9);
      key = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom);
      // narrow registers get noise above their width
      write_csr(khrt_pkg::REG_TARGET_KEY, {24'($urandom), key});
      write_csr(khrt_pkg::REG_TRIGGER_ON_RELEASE, {31'($urandom), 1'($urandom)});
      write_csr(khrt_pkg::REG_HOLD_DELAY, khrt_pkg::CSR_DATA_WIDTH'(pick_delay()));
      write_csr(khrt_pkg::REG_REPEAT_DELAY, khrt_pkg::CSR_DATA_WIDTH'(pick_delay()));
      if ($urandom_range(1) == 1) begin
         write_csr(khrt_pkg::CSR_INDEX_WIDTH'($urandom_range(
                      2 ** khrt_pkg::CSR_INDEX_WIDTH - 1,
                      khrt_pkg::REG_REPEAT_DELAY + 1)), $urandom);
      end
      settings_written++;
   endtask

   function automatic khrt_pkg::req_payload_type random_item();
      int sel;
      int psel;
      logic [7:0] pos;
      sel = $urandom_range(99);
      if (sel < 45) return mk_req(khrt_pkg::REQ_TICK, 8'($urandom), 8'($urandom));
      if (sel < 85) begin
         psel = $urandom_range(9);
         pos = (psel < 3) ? khrt_pkg::POS_PRESSED
             : (psel < 6) ? khrt_pkg::POS_RELEASED : 8'($urandom);
         return mk_req(khrt_pkg::REQ_KEY_EVENT, shadow_cfg.target_key, pos);
      end
      return mk_req(khrt_pkg::REQ_KEY_EVENT, 8'($urandom), 8'($urandom));
   endfunction

   function automatic dir_row_type item_row(bit typed, khrt_pkg::req_payload_type rq,
                                            khrt_pkg::results_type res);
      dir_row_type row;
      row.is_csr = 1'b0;
      row.index = '0;
      row.value = '0;
      row.req = rq;
      row.typed = typed;
      row.res = res;
      return row;
   endfunction

   function automatic dir_row_type csr_row(logic [khrt_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                           logic [khrt_pkg::CSR_DATA_WIDTH-1:0] value);
      dir_row_type row;
      row = item_row(1'b0, '0, '0);
      row.is_csr = 1'b1;
      row.index = idx;
      row.value = value;
      return row;
   endfunction

   initial begin
      int send_idle_tab[4];
      int stall_tab[4];
      int counted;
      khrt_pkg::req_payload_type rq;
      khrt_pkg::results_type none;

      send_idle_tab = '{0, 87, 0, 34};
      stall_tab = '{0, 0, 87, 34};
      none = mk_res(2'd0, khrt_pkg::EV_BEGIN, khrt_pkg::EV_BEGIN);

      // reset registers: key 0, trigger on press, both delays zero
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_TICK, 8'd0, 8'd0), none));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd0,
                                            khrt_pkg::POS_PRESSED),
                                  mk_res(2'd2, khrt_pkg::EV_BEGIN, khrt_pkg::EV_SUCCESS)));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_TICK, 8'd255, 8'd255),
                                  mk_res(2'd1, khrt_pkg::EV_SUCCESS, khrt_pkg::EV_BEGIN)));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd1,
                                            khrt_pkg::POS_PRESSED), none));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd0, 8'd128),
                                  mk_res(2'd1, khrt_pkg::EV_SUCCESS, khrt_pkg::EV_BEGIN)));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd0,
                                            khrt_pkg::POS_RELEASED),
                                  mk_res(2'd1, khrt_pkg::EV_CANCEL, khrt_pkg::EV_BEGIN)));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd0,
                                            khrt_pkg::POS_RELEASED), none));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd0, 8'd128), none));
      // release trigger on the top key code, short delays
      dir_rows.push_back(csr_row(khrt_pkg::REG_TARGET_KEY, 32'hABCD_EEFF));
      dir_rows.push_back(csr_row(khrt_pkg::REG_TRIGGER_ON_RELEASE, 32'hFFFF_FFFF));
      dir_rows.push_back(csr_row(khrt_pkg::REG_HOLD_DELAY, 32'd3));
      dir_rows.push_back(csr_row(khrt_pkg::REG_REPEAT_DELAY, 32'd2));
      dir_rows.push_back(csr_row(REG_UNUSED, 32'hFFFF_FFFF));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd255,
                                            khrt_pkg::POS_RELEASED),
                                  mk_res(2'd1, khrt_pkg::EV_BEGIN, khrt_pkg::EV_BEGIN)));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd255, 8'd77), none));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_TICK, 8'd0, 8'd0), none));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_TICK, 8'd0, 8'd0), none));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_TICK, 8'd0, 8'd0), none));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_TICK, 8'd255, 8'd255), none));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_TICK, 8'd0, 8'd0), none));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'd255,
                                            khrt_pkg::POS_PRESSED), none));
      // largest delays, press trigger
      dir_rows.push_back(csr_row(khrt_pkg::REG_TARGET_KEY, 32'h0000_005A));
      dir_rows.push_back(csr_row(khrt_pkg::REG_TRIGGER_ON_RELEASE, 32'h0000_0000));
      dir_rows.push_back(csr_row(khrt_pkg::REG_HOLD_DELAY, 32'hFFFF_FFFF));
      dir_rows.push_back(csr_row(khrt_pkg::REG_REPEAT_DELAY, 32'hFFFF_FFFF));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'h5A,
                                            khrt_pkg::POS_PRESSED), none));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_TICK, 8'd0, 8'd0), none));
      dir_rows.push_back(item_row(0, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'h5A, 8'd1), none));
      dir_rows.push_back(item_row(1, mk_req(khrt_pkg::REQ_KEY_EVENT, 8'h5A,
                                            khrt_pkg::POS_RELEASED),
                                  mk_res(2'd1, khrt_pkg::EV_CANCEL, khrt_pkg::EV_BEGIN)));

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            wait_idle();
            write_csr(dir_rows[i].index, dir_rows[i].value);
         end else begin
            send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
         end
      end
      settings_written += 3;

      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct = send_idle_tab[mode];
         stall_pct = stall_tab[mode];
         for (int blk = 0; blk < BLOCKS_PER_MODE; blk++) begin
            wait_idle();
            write_random_config();
            counted = 0;
            while (counted < ITEMS_PER_BLOCK) begin
               rq = random_item();
               counted++;
               send_item(rq, 1'b0, none);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_events.size() != 0) begin
         $error("%0d expected results never arrived", pending_events.size());
         failures++;
      end

      $display("summary: %0d transactions sent, %0d results checked, %0d failures",
               items_sent, results_checked, failures);
      $display("covered %0d register settings under four handshake pacing modes",
               settings_written);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: key_hold_repeat_trigger_core.f
rtl/khrt_pkg.sv
rtl/khrt_step.sv
rtl/khrt_rsp_buf.sv
rtl/key_hold_repeat_trigger_core.sv
sim/key_hold_repeat_trigger_core_test.sv
